@@ rtl/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

    typedef enum logic [2:0] {
        CMD_ADD_HEAD = 3'd0,
        CMD_ADD_TAIL = 3'd1,
        CMD_INSERT   = 3'd2,
        CMD_DEL_HEAD = 3'd3,
        CMD_DEL_TAIL = 3'd4,
        CMD_SEARCH   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    localparam int unsigned OUT_IDX_W = 7;
    localparam logic [OUT_IDX_W-1:0] FOUND_NONE = '1;

    // controller -> datapath
    typedef struct packed {
        logic    load_item;
        logic    idx_tail;
        logic    idx_zero;
        logic    idx_dec;
        logic    idx_inc;
        logic    rd_prev;
        logic    rd_next;
        logic    rd_cur;
        logic    wr_shift;
        logic    wr_value;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_found;
        logic    out_load;
        t_status status;
    } t_dp_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic bad_pos;
        logic idx_gt_at;
        logic idx_next_lt_cnt;
        logic idx_lt_cnt;
        logic match;
        logic out_busy;
        t_cmd cmd;
    } t_dp_stat;

endpackage

@@ rtl/olist_datapath.sv @@
// ----------------------------------------------------------------------------
// olist_datapath
// Entry memory, entry count, walk index, item and result registers.
// ----------------------------------------------------------------------------
module olist_datapath
    import olist_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_ctrl                    i_ctrl,
    output t_dp_stat                    o_stat,
    input  logic [2:0]                  i_command,
    input  logic signed [31:0]          i_value,
    input  logic [6:0]                  i_position,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [2:0]                  o_status,
    output logic signed [OUT_IDX_W-1:0] o_found_index,
    output logic [OUT_IDX_W-1:0]        o_entry_count
);

    localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned IW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;

    logic [31:0]          r_mem [CAPACITY];
    logic [31:0]          r_rdata;
    logic [IW-1:0]        r_count;
    logic [IW-1:0]        r_idx;
    t_cmd                 r_cmd;
    logic [31:0]          r_value;
    logic [6:0]           r_pos;
    logic [OUT_IDX_W-1:0] r_found;
    logic                 r_out_valid;
    logic [2:0]           r_out_status;
    logic [OUT_IDX_W-1:0] r_out_found;
    logic [OUT_IDX_W-1:0] r_out_count;

    logic [AW-1:0]        at;
    logic [IW:0]          idx_next;
    logic [IW-1:0]        idx_prev;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic [AW-1:0]        wr_addr;
    logic [31:0]          wr_data;
    logic                 wr_en;
    logic [CMPW-1:0]      idx_ext;
    logic [CMPW-1:0]      cnt_ext;

    // landing slot of a push or insert; only used once full/bad-position are ruled out
    always_comb begin
        priority if (r_cmd == CMD_ADD_HEAD) begin
            at = '0;
        end else if (r_cmd == CMD_ADD_TAIL) begin
            at = r_count[AW-1:0];
        end else begin
            at = AW'(r_pos);
        end
    end

    assign idx_next = {1'b0, r_idx} + (IW+1)'(1);
    assign idx_prev = r_idx - IW'(1);
    assign idx_ext  = CMPW'(r_idx);
    assign cnt_ext  = CMPW'(r_count);

    always_comb begin
        o_stat.full            = (r_count >= IW'(CAPACITY));
        o_stat.empty           = (r_count == '0);
        o_stat.bad_pos         = (CMPW'(r_pos) > cnt_ext);
        o_stat.idx_gt_at       = (r_idx > IW'(at));
        o_stat.idx_next_lt_cnt = (idx_next < {1'b0, r_count});
        o_stat.idx_lt_cnt      = (r_idx < r_count);
        o_stat.match           = (r_rdata == r_value);
        o_stat.out_busy        = r_out_valid && !i_out_ready;
        o_stat.cmd             = r_cmd;
    end

    always_comb begin
        rd_en   = i_ctrl.rd_prev || i_ctrl.rd_next || i_ctrl.rd_cur;
        priority if (i_ctrl.rd_prev) begin
            rd_addr = idx_prev[AW-1:0];
        end else if (i_ctrl.rd_next) begin
            rd_addr = idx_next[AW-1:0];
        end else begin
            rd_addr = r_idx[AW-1:0];
        end
        wr_en   = i_ctrl.wr_shift || i_ctrl.wr_value;
        wr_addr = i_ctrl.wr_shift ? r_idx[AW-1:0] : at;
        wr_data = i_ctrl.wr_shift ? r_rdata : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) begin
            r_cmd   <= t_cmd'(i_command);
            r_value <= i_value;
            r_pos   <= i_position;
            r_found <= FOUND_NONE;
        end else if (i_ctrl.set_found) begin
            r_found <= idx_ext[OUT_IDX_W-1:0];
        end
        priority if (i_ctrl.idx_tail) begin
            r_idx <= r_count;
        end else if (i_ctrl.idx_zero) begin
            r_idx <= '0;
        end else if (i_ctrl.idx_dec) begin
            r_idx <= idx_prev;
        end else if (i_ctrl.idx_inc) begin
            r_idx <= idx_next[IW-1:0];
        end
        if (i_ctrl.out_load) begin
            r_out_status <= i_ctrl.status;
            r_out_found  <= r_found;
            r_out_count  <= cnt_ext[OUT_IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.cnt_inc) begin
                r_count <= r_count + IW'(1);
            end else if (i_ctrl.cnt_dec) begin
                r_count <= r_count - IW'(1);
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_found;
    assign o_entry_count = r_out_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(CAPACITY))
        else $error("entry count above capacity");
    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.cnt_inc |-> !o_stat.full)
        else $error("count increment on full list");
    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.cnt_dec |-> !o_stat.empty)
        else $error("count decrement on empty list");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_load |-> !o_stat.out_busy)
        else $error("result loaded over a pending transaction");
`endif

endmodule

@@ rtl/olist_ctrl.sv @@
// ----------------------------------------------------------------------------
// olist_ctrl
// Command sequencer: decodes each transaction and steps the datapath through
// shift, close and search walks one entry at a time.
// ----------------------------------------------------------------------------
module olist_ctrl
    import olist_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_OPEN_RD,
        S_OPEN_WR,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.status = r_status;
        n_state       = r_state;
        n_status      = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load_item = 1'b1;
                    n_state          = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status = ST_OK;
                n_state  = S_FINISH;
                unique case (i_stat.cmd)
                    CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_INSERT: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                        end else if (i_stat.cmd == CMD_INSERT && i_stat.bad_pos) begin
                            n_status = ST_BADPOS;
                        end else begin
                            o_ctrl.idx_tail = 1'b1;
                            n_state         = S_OPEN_RD;
                        end
                    end
                    CMD_DEL_HEAD: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_ctrl.idx_zero = 1'b1;
                            n_state         = S_CLOSE_RD;
                        end
                    end
                    CMD_DEL_TAIL: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_ctrl.cnt_dec = 1'b1;
                        end
                    end
                    CMD_SEARCH: begin
                        o_ctrl.idx_zero = 1'b1;
                        n_state         = S_SRCH_RD;
                    end
                    default: begin
                    end
                endcase
            end
            // open a gap from the tail down to the landing slot
            S_OPEN_RD: begin
                if (i_stat.idx_gt_at) begin
                    o_ctrl.rd_prev = 1'b1;
                    n_state        = S_OPEN_WR;
                end else begin
                    o_ctrl.wr_value = 1'b1;
                    o_ctrl.cnt_inc  = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_OPEN_WR: begin
                o_ctrl.wr_shift = 1'b1;
                o_ctrl.idx_dec  = 1'b1;
                n_state         = S_OPEN_RD;
            end
            // pull every entry behind the head one slot toward the front
            S_CLOSE_RD: begin
                if (i_stat.idx_next_lt_cnt) begin
                    o_ctrl.rd_next = 1'b1;
                    n_state        = S_CLOSE_WR;
                end else begin
                    o_ctrl.cnt_dec = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_CLOSE_WR: begin
                o_ctrl.wr_shift = 1'b1;
                o_ctrl.idx_inc  = 1'b1;
                n_state         = S_CLOSE_RD;
            end
            S_SRCH_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_ctrl.rd_cur = 1'b1;
                    n_state       = S_SRCH_CMP;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_FINISH;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    o_ctrl.set_found = 1'b1;
                    n_state          = S_FINISH;
                end else begin
                    o_ctrl.idx_inc = 1'b1;
                    n_state        = S_SRCH_RD;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISPATCH))
        else $error("accepted transaction not dispatched");
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.wr_shift && o_ctrl.wr_value))
        else $error("two memory writes in one cycle");
    a_load_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.out_load |=> o_in_ready)
        else $error("not ready after result load");
`endif

endmodule

@@ rtl/ordered_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of signed 32-bit values with push, insert, pop and
// search commands.
//
// Input channel (i_in_valid / o_in_ready) carries command, value, position.
// Output channel (o_out_valid / i_out_ready) returns status, found index and
// entry count, one result per transaction, in order.
// One transaction at a time. Push and insert shift the entries at or behind the
// landing slot, pop front shifts count - 1 entries and search compares entries
// in order until a hit or the end of the list; pop back, error and unused
// commands walk nothing. The next transaction can be taken in the same cycle
// that the result becomes valid. Shift walks read and write each entry once,
// a search reads each entry once; read data is registered.
// Reset empties the list (count to zero, no memory clear) and drops any
// pending result. A result waits in the output register while the receiver
// stalls; the next transaction may be accepted and worked meanwhile, but its
// result is held back until the previous one is taken.
// ----------------------------------------------------------------------------
module ordered_list_engine_top
    import olist_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_command,
    input  logic signed [31:0]          i_value,
    input  logic [6:0]                  i_position,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_status,
    output logic signed [OUT_IDX_W-1:0] o_found_index,
    output logic [OUT_IDX_W-1:0]        o_entry_count
);

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    olist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    olist_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ sim/tb_ordered_list_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top
// Self-checking bench for the ordered list engine. A local list model predicts
// status, found index and entry count for every accepted command. Directed
// tests cover empty, single-entry and full lists and bad positions. Random
// phases then grow, shrink and churn the list, the first ones under random
// stalls on both channels and the last with none.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;
    import olist_pkg::*;

    localparam int unsigned CAPACITY     = 64;
    localparam int          DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 2000;

    // command codes the block treats as no-ops
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_IDX_W-1:0] found;
        logic [OUT_IDX_W-1:0] count;
    } t_list_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        o_in_ready;
    logic [2:0]                  command = '0;
    logic signed [31:0]          value = '0;
    logic [6:0]                  position = '0;
    logic                        o_out_valid;
    logic                        out_ready = 1'b0;
    logic [2:0]                  o_status;
    logic signed [OUT_IDX_W-1:0] o_found_index;
    logic [OUT_IDX_W-1:0]        o_entry_count;

    logic signed [31:0] list_model[$];
    t_list_result       pending_results[$];

    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int hold_request = 0;
    int err_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int peak_depth = 0;
    int status_hits[5] = '{default: 0};

    ordered_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (command),
        .i_value       (value),
        .i_position    (position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_count (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Applies one command to the local list and returns the result it gives.
    function automatic t_list_result apply_list_command(input logic [2:0] cmd,
                                                        input logic signed [31:0] val,
                                                        input logic [6:0] pos);
        t_list_result res;
        int           depth;
        depth      = list_model.size();
        res.status = ST_OK;
        res.found  = FOUND_NONE;
        case (cmd)
            CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_INSERT: begin
                if (depth >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (cmd == CMD_ADD_HEAD) begin
                    list_model.insert(0, val);
                end else if (cmd == CMD_ADD_TAIL) begin
                    list_model.insert(depth, val);
                end else if (int'(pos) > depth) begin
                    res.status = ST_BADPOS;
                end else begin
                    list_model.insert(int'(pos), val);
                end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL: begin
                if (depth == 0) begin
                    res.status = ST_EMPTY;
                end else if (cmd == CMD_DEL_HEAD) begin
                    list_model.delete(0);
                end else begin
                    list_model.delete(depth - 1);
                end
            end
            CMD_SEARCH: begin
                res.status = ST_NOTFOUND;
                for (int k = 0; k < depth; k++) begin
                    if (list_model[k] == val) begin
                        res.status = ST_OK;
                        res.found  = OUT_IDX_W'(k);
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.count = OUT_IDX_W'(list_model.size());
        return res;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'(int'($urandom_range(0, 8)) - 4);
        if (r == 4)
            return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
        return $urandom;
    endfunction

    // Offers one command and returns at the edge where it is taken.
    task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] val,
                             input logic [6:0] pos);
        t_list_result res;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        position <= pos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = apply_list_command(cmd, val, pos);
        pending_results.insert(pending_results.size(), res);
        status_hits[res.status]++;
        sent_count++;
        if (list_model.size() > peak_depth)
            peak_depth = list_model.size();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                out_ready   <= 1'b0;
                n            = hold_request;
                hold_request = 0;
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                n          = $urandom_range(1, 7);
            end else begin
                out_ready <= 1'b1;
                n          = $urandom_range(1, 10);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected transaction",
                              32'({o_status, o_found_index, o_entry_count}), 32'd0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                checked_count++;
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_found_index !== want.found)
                    flag_mismatch("found_index", 32'(o_found_index), 32'(want.found));
                if (o_entry_count !== want.count)
                    flag_mismatch("entry_count", 32'(o_entry_count), 32'(want.count));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL ordered_list_engine_top");
        $finish;
    end

    task automatic test_empty_list();
        send_item(CMD_DEL_HEAD, 32'sd1, 7'd0);
        send_item(CMD_DEL_TAIL, 32'sd1, 7'd0);
        send_item(CMD_SEARCH, 32'sd0, 7'd0);
        send_item(CMD_INSERT, 32'sd9, 7'd1);
        send_item(CMD_UNUSED_A, 32'sd3, 7'd0);
        send_item(CMD_UNUSED_B, 32'sh8000_0000, 7'd127);
        wait_drained();
    endtask

    task automatic test_edit_and_search();
        send_item(CMD_ADD_TAIL, 32'sh7fff_ffff, 7'd0);
        send_item(CMD_ADD_HEAD, 32'sh8000_0000, 7'd127);
        send_item(CMD_INSERT, 32'sd5, 7'd0);       // lands at the front
        send_item(CMD_INSERT, -32'sd1, 7'd3);      // position == count appends
        send_item(CMD_INSERT, 32'sd5, 7'd2);       // duplicate key further back
        send_item(CMD_INSERT, 32'sd8, 7'd127);
        send_item(CMD_INSERT, 32'sd8, 7'd6);
        send_item(CMD_SEARCH, 32'sd5, 7'd0);
        send_item(CMD_SEARCH, -32'sd1, 7'd0);
        send_item(CMD_SEARCH, 32'sh7fff_ffff, 7'd0);
        send_item(CMD_SEARCH, 32'sd123, 7'd0);
        send_item(CMD_DEL_HEAD, 32'sd0, 7'd0);
        send_item(CMD_DEL_TAIL, 32'sd0, 7'd0);
        send_item(CMD_DEL_TAIL, 32'sd0, 7'd0);
        send_item(CMD_DEL_TAIL, 32'sd0, 7'd0);
        send_item(CMD_DEL_TAIL, 32'sd0, 7'd0);     // single entry
        send_item(CMD_DEL_HEAD, 32'sd0, 7'd0);
        send_item(CMD_ADD_HEAD, 32'sd7, 7'd0);
        send_item(CMD_DEL_HEAD, 32'sd0, 7'd0);
        wait_drained();
    endtask

    task automatic test_full_list();
        for (int k = 0; k < CAPACITY; k++)
            send_item(CMD_ADD_TAIL, 32'sh1000_0000 + k, 7'($urandom));
        send_item(CMD_ADD_HEAD, 32'sd1, 7'd0);
        send_item(CMD_ADD_TAIL, 32'sd1, 7'd0);
        send_item(CMD_INSERT, 32'sd1, 7'd0);
        send_item(CMD_INSERT, 32'sd1, 7'd127);     // full wins over bad position
        send_item(CMD_SEARCH, 32'sh1000_0000 + CAPACITY - 1, 7'd0);
        send_item(CMD_SEARCH, 32'sh1000_0000, 7'd0);
        while (list_model.size() > 0)
            send_item((list_model.size() % 2 != 0) ? CMD_DEL_HEAD : CMD_DEL_TAIL,
                      pick_value(), 7'($urandom));
        wait_drained();
    endtask

    // Receiver holds off while commands keep coming, so the input stalls.
    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 16; k++)
            send_item((k % 4 == 3) ? CMD_SEARCH : CMD_ADD_HEAD, pick_value(), 7'd0);
        wait_drained();
    endtask

    task automatic run_random_phase(input int n_items, input int grow_pct);
        int unsigned        r;
        logic [2:0]         cmd;
        logic signed [31:0] val;
        logic [6:0]         pos;
        for (int k = 0; k < n_items; k++) begin
            r   = $urandom_range(0, 99);
            val = pick_value();
            pos = 7'($urandom_range(0, list_model.size()));
            if ($urandom_range(0, 4) == 0)
                pos = 7'($urandom_range(0, 127));
            if (r < 4) begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
            end else if (r < 4 + grow_pct) begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_ADD_HEAD;
                    1:       cmd = CMD_ADD_TAIL;
                    default: cmd = CMD_INSERT;
                endcase
            end else if (r < 85) begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_DEL_HEAD : CMD_DEL_TAIL;
            end else begin
                cmd = CMD_SEARCH;
                if (list_model.size() > 0 && $urandom_range(0, 9) < 7)
                    val = list_model[$urandom_range(0, list_model.size() - 1)];
            end
            send_item(cmd, val, pos);
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edit_and_search();
        test_full_list();
        test_output_backpressure();
        run_random_phase(200, 60);
        run_random_phase(175, 25);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        run_random_phase(100, 40);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("results still outstanding", pending_results.size(), 0);

        $display("%0d commands sent, %0d results checked, list depth peaked at %0d of %0d",
                 sent_count, checked_count, peak_depth, CAPACITY);
        $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_BADPOS], status_hits[ST_NOTFOUND]);
        if (err_count == 0) begin
            $display("PASS ordered_list_engine_top");
        end else begin
            $display("FAIL ordered_list_engine_top");
        end
        $finish;
    end

endmodule
